// File: sv/assert_macros.svh
// Assertion macros used by the top level of the slot tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, ignored while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen on a rising edge of clk.
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

// File: sv/sst_pkg.sv
// Shared constants and types of the slot tracker.
`timescale 1ns / 1ps

package sst_pkg;

    // Table geometry
    localparam int SLOT_COUNT  = 64;
    localparam int GUID_BITS   = 64;
    localparam int IDX_W       = $clog2(SLOT_COUNT);

    // Fixed port widths
    localparam int SLOT_W      = 7;
    localparam int GUID_PORT_W = 64;
    localparam int REQ_W       = 2;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [GUID_BITS-1:0]  guid_t;
    typedef logic [SLOT_COUNT-1:0] map_t;
    typedef logic [REQ_W-1:0]      req_t;

    // Request codes
    localparam req_t REQ_TRACK  = 2'd0;
    localparam req_t REQ_REMOVE = 2'd1;
    localparam req_t REQ_POP    = 2'd2;
    localparam req_t REQ_FIND   = 2'd3;

    // Slot value meaning full, empty or not found
    localparam slot_t SLOT_NONE = slot_t'(SLOT_COUNT);
    // First slot visited by a scan
    localparam idx_t  IDX_TOP   = idx_t'(SLOT_COUNT - 1);

endpackage

// File: sv/sst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/sst_cmp.sv
// Shared identifier comparator; entries never written read as zero.
`timescale 1ns / 1ps

module sst_cmp (
    input  sst_pkg::guid_t entry,
    input  logic           entry_vld,
    input  sst_pkg::guid_t key,
    output logic           match
);

    sst_pkg::guid_t entry_eff;

    // Unwritten entries hold their reset value of zero
    assign entry_eff = entry_vld ? entry : '0;
    assign match     = (entry_eff == key);

endmodule

// File: sv/tagged_slot_tracker.sv
// Top level of the slot tracker: request sequencer, free bitmap and identifier store.
//
//  channel   | handshake        | ports
//  ----------+------------------+-------------------------------
//  request   | start & !busy    | req_type, guid, slot_id
//  result    | done (1 cycle)   | slot, success
//
// Remove: store read at slot_id registered on the accepting edge, compare in ST_RCMP, then
// the registered result strobe; an out-of-range slot_id is answered on the accepting edge.
// Track and pop: one slot of the free bitmap tested per cycle from the top down.
// Find: one store read per cycle through the shared comparator.
// busy drops in the cycle of the result strobe, so the next transaction can be taken then.
// After reset every slot is free and the store reads as zero (per-entry written bits);
// results cannot be stalled: done is high for one cycle per result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tagged_slot_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  sst_pkg::req_t                   req_type,
    input  logic [sst_pkg::GUID_PORT_W-1:0] guid,
    input  sst_pkg::slot_t                  slot_id,
    output logic                            done,
    output sst_pkg::slot_t                  slot,
    output logic                            success
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_RCMP  = 2'd3;

    logic [1:0]     state_reg, state_next;
    sst_pkg::req_t  req_reg, req_next;
    sst_pkg::guid_t key_reg, key_next;
    sst_pkg::idx_t  sid_reg, sid_next;
    sst_pkg::idx_t  idx_reg, idx_next;
    sst_pkg::idx_t  pend_idx_reg, pend_idx_next;
    logic           pend_vld_reg, pend_vld_next;
    sst_pkg::map_t  free_reg, free_next;
    sst_pkg::map_t  written_reg, written_next;
    logic           done_reg, done_next;
    sst_pkg::slot_t slot_reg, slot_next;
    logic           success_reg, success_next;

    logic           ram_we;
    sst_pkg::idx_t  ram_raddr;
    sst_pkg::guid_t ram_rdata;
    sst_pkg::idx_t  cmp_idx;
    logic           match;

    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign slot    = slot_reg;
    assign success = success_reg;

    // Store read: slot_id on the accepting edge (remove), scan index otherwise
    assign ram_raddr = busy ? idx_reg : slot_id[sst_pkg::IDX_W-1:0];
    assign cmp_idx   = (state_reg == ST_RCMP) ? sid_reg : pend_idx_reg;

    sst_ram #(
        .WIDTH (sst_pkg::GUID_BITS),
        .DEPTH (sst_pkg::SLOT_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (key_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sst_cmp u_cmp (
        .entry     (ram_rdata),
        .entry_vld (written_reg[cmp_idx]),
        .key       (key_reg),
        .match     (match)
    );

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        key_next      = key_reg;
        sid_next      = sid_reg;
        idx_next      = idx_reg;
        pend_idx_next = pend_idx_reg;
        pend_vld_next = pend_vld_reg;
        free_next     = free_reg;
        written_next  = written_reg;
        done_next     = 1'b0;
        slot_next     = slot_reg;
        success_next  = success_reg;
        ram_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next      = req_type;
                    key_next      = guid[sst_pkg::GUID_BITS-1:0];
                    sid_next      = slot_id[sst_pkg::IDX_W-1:0];
                    idx_next      = sst_pkg::IDX_TOP;
                    pend_vld_next = 1'b0;
                    if (req_type == sst_pkg::REQ_REMOVE)
                    begin
                        if (slot_id >= sst_pkg::slot_t'(sst_pkg::SLOT_COUNT))
                        begin
                            done_next    = 1'b1;
                            slot_next    = sst_pkg::SLOT_NONE;
                            success_next = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_RCMP;
                        end
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                unique case (req_reg)
                    sst_pkg::REQ_TRACK:
                    begin
                        if (free_reg[idx_reg])
                        begin
                            ram_we                = 1'b1;
                            free_next[idx_reg]    = 1'b0;
                            written_next[idx_reg] = 1'b1;
                            done_next             = 1'b1;
                            slot_next             = sst_pkg::slot_t'(idx_reg);
                            success_next          = 1'b1;
                            state_next            = ST_IDLE;
                        end
                        else if (idx_reg == '0)
                        begin
                            done_next    = 1'b1;
                            slot_next    = sst_pkg::SLOT_NONE;
                            success_next = 1'b0;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg - sst_pkg::idx_t'(1);
                        end
                    end

                    sst_pkg::REQ_POP:
                    begin
                        if (!free_reg[idx_reg])
                        begin
                            free_next[idx_reg] = 1'b1;
                            done_next          = 1'b1;
                            slot_next          = sst_pkg::slot_t'(idx_reg);
                            success_next       = 1'b1;
                            state_next         = ST_IDLE;
                        end
                        else if (idx_reg == '0)
                        begin
                            done_next    = 1'b1;
                            slot_next    = sst_pkg::SLOT_NONE;
                            success_next = 1'b0;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg - sst_pkg::idx_t'(1);
                        end
                    end

                    sst_pkg::REQ_FIND:
                    begin
                        // Read of idx in flight while the previous slot is compared
                        pend_vld_next = !free_reg[idx_reg];
                        pend_idx_next = idx_reg;
                        if (pend_vld_reg && match)
                        begin
                            done_next    = 1'b1;
                            slot_next    = sst_pkg::slot_t'(pend_idx_reg);
                            success_next = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        else if (idx_reg == '0)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            idx_next = idx_reg - sst_pkg::idx_t'(1);
                        end
                    end

                    sst_pkg::REQ_REMOVE:
                    begin
                        // Remove never scans
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_DRAIN:
            begin
                // Compare of the lowest slot
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (pend_vld_reg && match)
                begin
                    slot_next    = sst_pkg::slot_t'(pend_idx_reg);
                    success_next = 1'b1;
                end
                else
                begin
                    slot_next    = sst_pkg::SLOT_NONE;
                    success_next = 1'b0;
                end
            end

            ST_RCMP:
            begin
                // Remove frees the slot on a match, used or not
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (match)
                begin
                    free_next[sid_reg] = 1'b1;
                    slot_next          = sst_pkg::slot_t'(sid_reg);
                    success_next       = 1'b1;
                end
                else
                begin
                    slot_next    = sst_pkg::SLOT_NONE;
                    success_next = 1'b0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pend_vld_reg <= 1'b0;
            free_reg     <= '1;
            written_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            free_reg     <= free_next;
            written_reg  <= written_next;
            done_reg     <= done_next;
        end
    end

    // Transaction payload and scan position
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        key_reg      <= key_next;
        sid_reg      <= sid_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        slot_reg     <= slot_next;
        success_reg  <= success_next;
    end

    // Checks
    `ASSERT_CLK(a_strobe_idle, done_reg |-> !busy, "result strobe while the sequencer is busy")
    `ASSERT_CLK(a_store_write_ends, ram_we |=> done_reg, "store write without a track result")
    `ASSERT_CLK(a_map_on_result, !$stable(free_reg) |-> done_reg,
                "free bitmap changed without a result")
    `ASSERT_CLK(a_hit_slot_range,
                done_reg && success_reg |-> slot_reg < sst_pkg::slot_t'(sst_pkg::SLOT_COUNT),
                "successful result with slot out of range")
    `ASSERT_NEVER(a_miss_slot_none,
                  done_reg && !success_reg && slot_reg != sst_pkg::SLOT_NONE,
                  "failed result without the none slot value")

endmodule

// File: tb/tb.sv
// Testbench of the slot tracker: directed and random requests checked against a built-in predictor.
`timescale 1ns / 1ps

module tb;
    import sst_pkg::*;

    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    SETTLE_CYCLES  = SLOT_COUNT + 8;
    localparam int    MAX_GAP        = 100;
    localparam int    PRINT_LIMIT    = 40;
    localparam guid_t GUID_ONES      = '1;
    localparam guid_t GUID_ZERO      = '0;

    typedef struct {
        req_t  req;
        slot_t slot;
        logic  success;
    } slot_result_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   start    = 1'b0;
    logic                   busy;
    req_t                   req_type = REQ_TRACK;
    logic [GUID_PORT_W-1:0] guid     = '0;
    slot_t                  slot_id  = '0;
    logic                   done;
    slot_t                  slot;
    logic                   success;

    // Predictor state: a set bit in free_map marks a free slot
    map_t  free_map;
    guid_t entry_store [SLOT_COUNT];

    slot_result_t expected_results [$];
    int           mismatches      = 0;
    int           sender_idle_pct = 0;
    int           idle_cycles     = 0;

    tagged_slot_tracker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .guid     (guid),
        .slot_id  (slot_id),
        .done     (done),
        .slot     (slot),
        .success  (success)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Highest set bit of a map, or SLOT_NONE
    function automatic slot_t highest_slot(input map_t m);
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (m[i])
                return slot_t'(i);
        end
        return SLOT_NONE;
    endfunction

    // Applies one request to the predictor state and returns its result
    function automatic slot_result_t predict_result(input req_t req, input guid_t g,
                                                    input slot_t sid);
        slot_result_t r;
        map_t         hits;
        r.req     = req;
        r.slot    = SLOT_NONE;
        r.success = 1'b0;
        hits      = '0;
        case (req)
            REQ_TRACK:
            begin
                r.slot = highest_slot(free_map);
                if (r.slot != SLOT_NONE)
                begin
                    free_map[r.slot[IDX_W-1:0]]    = 1'b0;
                    entry_store[r.slot[IDX_W-1:0]] = g;
                    r.success = 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                // no in-use check: a free slot with a matching value is freed again
                if (sid < SLOT_COUNT && entry_store[sid[IDX_W-1:0]] == g)
                begin
                    free_map[sid[IDX_W-1:0]] = 1'b1;
                    r.slot    = sid;
                    r.success = 1'b1;
                end
            end
            REQ_POP:
            begin
                r.slot = highest_slot(~free_map);
                if (r.slot != SLOT_NONE)
                begin
                    free_map[r.slot[IDX_W-1:0]] = 1'b1;
                    r.success = 1'b1;
                end
            end
            default:
            begin
                // only used slots may match
                for (int i = 0; i < SLOT_COUNT; i++)
                    hits[i] = !free_map[i] && entry_store[i] == g;
                r.slot    = highest_slot(hits);
                r.success = r.slot != SLOT_NONE;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Sends one request, after a random gap, and records its expected result
    task automatic send_request(input req_t req, input guid_t g, input slot_t sid);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= req;
        guid     <= g;
        slot_id  <= sid;
        do
            @(posedge clk);
        while (busy);
        expected_results.push_back(predict_result(req, g, sid));
    endtask

    // Holds the sender off until every outstanding result has come back
    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    function automatic guid_t random_guid();
        return {$urandom, $urandom};
    endfunction

    // Random slot that is free (want_free = 1) or used, or -1 if there is none
    function automatic int pick_slot(input logic want_free);
        int cands [$];
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (free_map[i] == want_free)
                cands.push_back(i);
        end
        if (cands.size() == 0)
            return -1;
        return cands[$urandom_range(cands.size() - 1)];
    endfunction

    // Empty table: pop and find fail, remove hits the zeroed store, range check
    task automatic test_empty_table();
        send_request(REQ_POP,    random_guid(), slot_t'(0));
        send_request(REQ_FIND,   GUID_ZERO,     slot_t'(0));
        send_request(REQ_REMOVE, GUID_ZERO,     slot_t'(5));
        send_request(REQ_REMOVE, GUID_ZERO,     slot_t'(SLOT_COUNT));
        send_request(REQ_REMOVE, GUID_ZERO,     slot_t'(127));
    endtask

    // Fill from the top, duplicate identifiers, find hit and miss
    task automatic test_track_and_find();
        send_request(REQ_TRACK, GUID_ONES,               slot_t'(127));
        send_request(REQ_TRACK, GUID_ZERO,               slot_t'(0));
        send_request(REQ_TRACK, 64'h8000_0000_0000_0001, slot_t'(42));
        send_request(REQ_TRACK, GUID_ONES,               slot_t'(85));
        send_request(REQ_FIND,  GUID_ONES,               slot_t'(0));
        send_request(REQ_FIND,  GUID_ZERO,               slot_t'(127));
        send_request(REQ_FIND,  64'h0000_0000_0000_1234, slot_t'(0));
    endtask

    // Mismatched remove, remove twice, freed slot ignored by find
    task automatic test_remove_rules();
        send_request(REQ_REMOVE, 64'h7FFF_FFFF_FFFF_FFFF, slot_t'(IDX_TOP));
        send_request(REQ_REMOVE, GUID_ONES,               slot_t'(IDX_TOP));
        send_request(REQ_FIND,   GUID_ONES,               slot_t'(0));
        send_request(REQ_REMOVE, GUID_ONES,               slot_t'(IDX_TOP));
        send_request(REQ_REMOVE, GUID_ONES,               slot_t'(70));
    endtask

    // Pop order, track reusing a freed top slot, pop down to empty
    task automatic test_pop_order();
        send_request(REQ_POP,   GUID_ZERO,               slot_t'(0));
        send_request(REQ_TRACK, 64'h5555_5555_AAAA_AAAA, slot_t'(0));
        send_request(REQ_POP,   GUID_ONES,               slot_t'(127));
        send_request(REQ_POP,   GUID_ZERO,               slot_t'(0));
        send_request(REQ_POP,   GUID_ZERO,               slot_t'(0));
        send_request(REQ_POP,   GUID_ZERO,               slot_t'(0));
    endtask

    // Bursts that fill, drain or mix the table, mostly with identifiers that match
    task automatic test_random_traffic(input int n_items);
        guid_t pool [8];
        int    sent;
        int    burst;
        int    mode;
        int    roll;
        int    s;
        req_t  req;
        guid_t g;
        slot_t sid;
        pool[0] = GUID_ZERO;
        pool[1] = GUID_ONES;
        for (int k = 2; k < 8; k++)
            pool[k] = random_guid();
        sent = 0;
        while (sent < n_items)
        begin
            mode  = $urandom_range(2);
            burst = $urandom_range(20, 100);
            for (int b = 0; b < burst && sent < n_items; b++)
            begin
                roll = $urandom_range(99);
                case (mode)
                    0:       req = roll < 70 ? REQ_TRACK : roll < 85 ? REQ_FIND :
                                   roll < 95 ? REQ_REMOVE : REQ_POP;
                    1:       req = roll < 10 ? REQ_TRACK : roll < 45 ? REQ_REMOVE :
                                   roll < 80 ? REQ_POP : REQ_FIND;
                    default: req = roll < 25 ? REQ_TRACK : roll < 50 ? REQ_REMOVE :
                                   roll < 75 ? REQ_POP : REQ_FIND;
                endcase
                g    = random_guid();
                sid  = slot_t'($urandom_range(127));
                roll = $urandom_range(99);
                case (req)
                    REQ_TRACK:
                    begin
                        if (roll < 60)
                            g = pool[$urandom_range(7)];
                    end
                    REQ_REMOVE:
                    begin
                        // used slot, free slot, any slot; else fully random fields
                        if (roll < 70)
                            s = pick_slot(1'b0);
                        else if (roll < 80)
                            s = pick_slot(1'b1);
                        else if (roll < 90)
                            s = $urandom_range(SLOT_COUNT - 1);
                        else
                            s = -1;
                        if (s >= 0)
                        begin
                            sid = slot_t'(s);
                            g   = roll < 80 ? entry_store[s] : pool[$urandom_range(7)];
                        end
                    end
                    REQ_FIND:
                    begin
                        if (roll < 50)
                            s = pick_slot(1'b0);
                        else if (roll < 60)
                            s = pick_slot(1'b1);
                        else
                            s = -1;
                        if (s >= 0)
                            g = entry_store[s];
                        else if (roll < 90)
                            g = pool[$urandom_range(7)];
                    end
                    default:
                    begin
                    end
                endcase
                send_request(req, g, sid);
                sent++;
            end
            if ($urandom_range(3) == 0)
                wait_for_results();
        end
        wait_for_results();
    endtask

    // Result checking: each strobe is matched against the oldest expectation
    always @(posedge clk)
    begin
        slot_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result slot=%0d success=%0b",
                                          slot, success));
            else
            begin
                want = expected_results.pop_front();
                if (slot !== want.slot)
                    report_mismatch($sformatf("req %0d: slot %0d, want %0d",
                                              want.req, slot, want.slot));
                if (success !== want.success)
                    report_mismatch($sformatf("req %0d: success %0b, want %0b",
                                              want.req, success, want.success));
            end
        end
    end

    // Watchdog: too long with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        free_map = '1;
        foreach (entry_store[i])
            entry_store[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 16;
        test_empty_table();
        test_track_and_find();
        test_remove_rules();
        test_pop_order();
        test_random_traffic(476);

        sender_idle_pct = 70;
        test_random_traffic(476);

        sender_idle_pct = 0;
        test_random_traffic(476);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
